/* src/lbe_pkg.sv */
// Shared types, codes and constants of the ladder button event generator.
package lbe_pkg;

	// Number of ADC samples that each ladder channel brings per poll.
	localparam int SAMPLES_PER_CHANNEL = 3;

	// Default depth of the result queue.
	localparam int RES_DEPTH_DEFAULT = 4;

	// Nominal ladder levels.
	localparam logic [11:0] LVL_RIGHT   = 12'd3;
	localparam logic [11:0] LVL_LEFT    = 12'd1470;
	localparam logic [11:0] LVL_CONFIRM = 12'd2655;
	localparam logic [11:0] LVL_BACK    = 12'd3470;
	localparam logic [11:0] LVL_VOLDOWN = 12'd3;
	localparam logic [11:0] LVL_VOLUP   = 12'd2205;

	// Button codes.
	localparam logic [2:0] KEY_NONE     = 3'd0;
	localparam logic [2:0] KEY_RIGHT    = 3'd1;
	localparam logic [2:0] KEY_LEFT     = 3'd2;
	localparam logic [2:0] KEY_OK       = 3'd3;
	localparam logic [2:0] KEY_RETURN   = 3'd4;
	localparam logic [2:0] KEY_VOL_DOWN = 3'd5;
	localparam logic [2:0] KEY_VOL_UP   = 3'd6;
	localparam logic [2:0] KEY_POWER    = 3'd7;

	// Event codes.
	localparam logic [1:0] EV_PRESSED  = 2'd0;
	localparam logic [1:0] EV_RELEASED = 2'd1;
	localparam logic [1:0] EV_LONG     = 2'd2;
	localparam logic [1:0] EV_REPEAT   = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_DEBOUNCE_EN    = 3'd0;
	localparam logic [2:0] CFG_LONG_EN        = 3'd1;
	localparam logic [2:0] CFG_REPEAT_EN      = 3'd2;
	localparam logic [2:0] CFG_DEBOUNCE_TIME  = 3'd3;
	localparam logic [2:0] CFG_LONG_TIME      = 3'd4;
	localparam logic [2:0] CFG_REPEAT_FIRST   = 3'd5;
	localparam logic [2:0] CFG_REPEAT_PERIOD  = 3'd6;
	localparam logic [2:0] CFG_TOLERANCE      = 3'd7;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        power_pin_low;
		logic [11:0] ladder_a_sample0;
		logic [11:0] ladder_a_sample1;
		logic [11:0] ladder_a_sample2;
		logic [11:0] ladder_b_sample0;
		logic [11:0] ladder_b_sample1;
		logic [11:0] ladder_b_sample2;
	} in_item_t;

	typedef struct packed {
		logic [2:0] button_id;
		logic [1:0] event_kind;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic        debounce_enable;
		logic        long_press_enable;
		logic        repeat_enable;
		logic [15:0] debounce_time;
		logic [15:0] long_press_time;
		logic [15:0] repeat_first_delay;
		logic [15:0] repeat_period;
		logic [11:0] level_tolerance;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		debounce_enable:    1'b1,
		long_press_enable:  1'b1,
		repeat_enable:      1'b1,
		debounce_time:      16'd20,
		long_press_time:    16'd1000,
		repeat_first_delay: 16'd500,
		repeat_period:      16'd100,
		level_tolerance:    12'd100
	};

	// Up to two results written into the result queue in one cycle.
	// push1 is only ever set together with push0.
	typedef struct packed {
		logic      push0;
		logic      push1;
		out_item_t item0;
		out_item_t item1;
	} res_push_t;

	function automatic out_item_t mk_item(logic [2:0] btn, logic [1:0] ev, logic last);
		out_item_t r;
		r.button_id   = btn;
		r.event_kind  = ev;
		r.last_of_run = last;
		return r;
	endfunction

endpackage

/* src/lbe_decode.sv */
// Button decode: channel sums against scaled ladder windows, by priority.
module lbe_decode (
	input  lbe_pkg::in_item_t  item,
	input  logic [11:0]        tolerance,
	output logic [2:0]         button
);
	import lbe_pkg::*;

	// floor(sum / 3) < K holds exactly when sum < 3 * K, so the average is
	// never formed and the window bounds are scaled instead.
	function automatic logic [14:0] thr3(logic [11:0] lvl, logic [11:0] tol);
		logic [12:0] bound;
		bound = {1'b0, lvl} + {1'b0, tol};
		return {2'b00, bound} + {1'b0, bound, 1'b0};
	endfunction

	logic [13:0] sum_a;
	logic [13:0] sum_b;

	assign sum_a = {2'b00, item.ladder_a_sample0} + {2'b00, item.ladder_a_sample1}
		+ {2'b00, item.ladder_a_sample2};
	assign sum_b = {2'b00, item.ladder_b_sample0} + {2'b00, item.ladder_b_sample1}
		+ {2'b00, item.ladder_b_sample2};

	always_comb begin
		if (item.power_pin_low) begin
			button = KEY_POWER;
		end else if ({1'b0, sum_a} < thr3(LVL_RIGHT, tolerance)) begin
			button = KEY_RIGHT;
		end else if ({1'b0, sum_a} < thr3(LVL_LEFT, tolerance)) begin
			button = KEY_LEFT;
		end else if ({1'b0, sum_a} < thr3(LVL_CONFIRM, tolerance)) begin
			button = KEY_OK;
		end else if ({1'b0, sum_a} < thr3(LVL_BACK, tolerance)) begin
			button = KEY_RETURN;
		end else if ({1'b0, sum_b} < thr3(LVL_VOLDOWN, tolerance)) begin
			button = KEY_VOL_DOWN;
		end else if ({1'b0, sum_b} < thr3(LVL_VOLUP, tolerance)) begin
			button = KEY_VOL_UP;
		end else begin
			button = KEY_NONE;
		end
	end

endmodule

/* src/lbe_engine.sv */
// Press tracking state and event generation for one decoded poll a cycle while enabled.
module lbe_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enable,
	input  logic [31:0]         now_ms,
	input  logic [2:0]          button,
	input  lbe_pkg::cfg_t       cfg,
	output lbe_pkg::res_push_t  push
);
	import lbe_pkg::*;

	logic [2:0]  held_button_q, held_button_n;
	logic        is_held_q, is_held_n;
	logic        awaiting_q, awaiting_n;
	logic        long_sent_q, long_sent_n;
	logic        repeated_q, repeated_n;
	logic [31:0] press_stamp_q, press_stamp_n;
	logic [31:0] last_stamp_q, last_stamp_n;

	logic [31:0] since_press;
	logic [31:0] since_last;
	logic [15:0] rep_gap;
	logic        long_hit;
	logic        rep_hit;
	res_push_t   push_c;

	assign since_press = now_ms - press_stamp_q;
	assign since_last  = now_ms - last_stamp_q;
	assign rep_gap     = repeated_q ? cfg.repeat_period : cfg.repeat_first_delay;
	assign long_hit    = cfg.long_press_enable && !long_sent_q
		&& (since_press >= {16'd0, cfg.long_press_time});
	assign rep_hit     = cfg.repeat_enable && (since_last >= {16'd0, rep_gap});

	always_comb begin
		held_button_n = held_button_q;
		is_held_n     = is_held_q;
		awaiting_n    = awaiting_q;
		long_sent_n   = long_sent_q;
		repeated_n    = repeated_q;
		press_stamp_n = press_stamp_q;
		last_stamp_n  = last_stamp_q;
		push_c        = '0;

		if (is_held_q && awaiting_q) begin
			// Polls before the confirming time leave everything untouched.
			if (since_press >= {16'd0, cfg.debounce_time}) begin
				if (button == held_button_q) begin
					awaiting_n   = 1'b0;
					push_c.push0 = 1'b1;
					push_c.item0 = mk_item(held_button_q, EV_PRESSED, 1'b1);
				end else begin
					held_button_n = KEY_NONE;
					is_held_n     = 1'b0;
					awaiting_n    = 1'b0;
					long_sent_n   = 1'b0;
					repeated_n    = 1'b0;
				end
			end
		end else if (button == KEY_NONE) begin
			if (is_held_q) begin
				push_c.push0  = 1'b1;
				push_c.item0  = mk_item(held_button_q, EV_RELEASED, 1'b1);
				held_button_n = KEY_NONE;
				is_held_n     = 1'b0;
				awaiting_n    = 1'b0;
				long_sent_n   = 1'b0;
				repeated_n    = 1'b0;
			end
		end else if (!is_held_q) begin
			held_button_n = button;
			is_held_n     = 1'b1;
			long_sent_n   = 1'b0;
			repeated_n    = 1'b0;
			press_stamp_n = now_ms;
			last_stamp_n  = now_ms;
			if (cfg.debounce_enable && (cfg.debounce_time != 16'd0)) begin
				awaiting_n = 1'b1;
			end else begin
				push_c.push0 = 1'b1;
				push_c.item0 = mk_item(button, EV_PRESSED, 1'b1);
			end
		end else begin
			// Held: events carry the button seen on this poll.
			if (long_hit) begin
				long_sent_n  = 1'b1;
				push_c.push0 = 1'b1;
				push_c.item0 = mk_item(button, EV_LONG, !rep_hit);
				if (rep_hit) begin
					push_c.push1 = 1'b1;
					push_c.item1 = mk_item(button, EV_REPEAT, 1'b1);
				end
			end else if (rep_hit) begin
				push_c.push0 = 1'b1;
				push_c.item0 = mk_item(button, EV_REPEAT, 1'b1);
			end
			if (rep_hit) begin
				repeated_n   = 1'b1;
				last_stamp_n = now_ms;
			end
		end
	end

	always_comb begin
		push       = push_c;
		push.push0 = push_c.push0 && enable;
		push.push1 = push_c.push1 && enable;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_button_q <= KEY_NONE;
			is_held_q     <= 1'b0;
			awaiting_q    <= 1'b0;
			long_sent_q   <= 1'b0;
			repeated_q    <= 1'b0;
			press_stamp_q <= '0;
			last_stamp_q  <= '0;
		end else if (enable) begin
			held_button_q <= held_button_n;
			is_held_q     <= is_held_n;
			awaiting_q    <= awaiting_n;
			long_sent_q   <= long_sent_n;
			repeated_q    <= repeated_n;
			press_stamp_q <= press_stamp_n;
			last_stamp_q  <= last_stamp_n;
		end
	end

endmodule

/* src/lbe_result_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
module lbe_result_fifo #(
	parameter int DEPTH = lbe_pkg::RES_DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbe_pkg::res_push_t         push,
	output logic                       room,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lbe_pkg::out_item_t         out_data
);
	import lbe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH-1)) ? '0 : p + PW'(1);
	endfunction

	out_item_t     mem_q [DEPTH];
	logic [PW-1:0] rd_ptr_q;
	logic [PW-1:0] wr_ptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_ptr_p1;
	logic          pop;

	assign wr_ptr_p1 = inc(wr_ptr_q);
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign count     = count_q;
	// A poll may cause two results, so two free places are needed.
	assign room      = (count_q <= CW'(DEPTH-2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			if (push.push1) begin
				wr_ptr_q <= inc(wr_ptr_p1);
			end else if (push.push0) begin
				wr_ptr_q <= wr_ptr_p1;
			end
			count_q <= count_q + CW'(push.push0) + CW'(push.push1) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wr_ptr_q] <= push.item0;
		end
		if (push.push1) begin
			mem_q[wr_ptr_p1] <= push.item1;
		end
	end

endmodule

/* src/ladder_button_event_generator.sv */
// Top level of the ladder button event generator: input stage, config and assembly.
//
// Each poll beat is taken into an input register and, once the result queue has
// two free places, decoded and run through the press tracker in one pass; its zero,
// one or two events land in a result queue of RES_DEPTH entries and leave it one
// beat a cycle while the receiver is ready. A new poll is accepted every cycle
// while the queue has two free places, and the sustained rate is set by the queue
// output: one event beat per cycle. The first event of a poll is offered once it
// has passed the input register and been written into the result queue.
// Configuration writes take effect at once and should only be made while no poll
// is in flight.
module ladder_button_event_generator #(
	parameter int RES_DEPTH = lbe_pkg::RES_DEPTH_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lbe_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output lbe_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [lbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import lbe_pkg::*;

	localparam int CW = $clog2(RES_DEPTH+1);

	cfg_t          cfg_q;
	in_item_t      in_data_s1;
	logic          in_valid_s1;
	logic          room;
	logic [CW-1:0] res_count;
	logic          process;
	logic [2:0]    button;
	res_push_t     push;

	assign process  = in_valid_s1 && room;
	assign in_ready = !in_valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE_EN:   cfg_q.debounce_enable    <= cfg_wdata[0];
				CFG_LONG_EN:       cfg_q.long_press_enable  <= cfg_wdata[0];
				CFG_REPEAT_EN:     cfg_q.repeat_enable      <= cfg_wdata[0];
				CFG_DEBOUNCE_TIME: cfg_q.debounce_time      <= cfg_wdata;
				CFG_LONG_TIME:     cfg_q.long_press_time    <= cfg_wdata;
				CFG_REPEAT_FIRST:  cfg_q.repeat_first_delay <= cfg_wdata;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period      <= cfg_wdata;
				CFG_TOLERANCE:     cfg_q.level_tolerance    <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
	end

	lbe_decode u_decode (
		.item      (in_data_s1),
		.tolerance (cfg_q.level_tolerance),
		.button    (button)
	);

	lbe_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.enable (process),
		.now_ms (in_data_s1.now_ms),
		.button (button),
		.cfg    (cfg_q),
		.push   (push)
	);

	lbe_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.count     (res_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// The result queue never holds more than it has places for.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_count <= CW'(RES_DEPTH))
		else $error("result queue overflow");

	// Exactly the final result written for a poll carries the end-of-run mark.
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push.push0 |-> (push.push1 ? (push.item1.last_of_run && !push.item0.last_of_run)
			: push.item0.last_of_run))
		else $error("end-of-run mark misplaced");

	// A second result is never written without a first one.
	a_push_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.push1 |-> push.push0)
		else $error("second result without first");

	// A poll that waits in the input register is not lost.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !process) |=> in_valid_s1)
		else $error("stalled poll dropped");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the ladder button event generator.
module tb;
	import lbe_pkg::*;

	localparam int CLK_HALF       = 2;
	localparam int RUN_LIMIT      = 2000000;
	localparam int RANDOM_POLLS   = 2000;
	localparam int IDLE_PCT       = 9;
	localparam int SETTLE_CYCLES  = 8;
	localparam int STALL_CYCLES   = 120;
	localparam int STALL_AT_POLL  = 1300;
	localparam int STEADY_FROM    = 600;
	localparam int STEADY_TO      = 900;
	localparam int MAX_REPORTS    = 100;
	localparam int PREDICTED      = -1;
	localparam int NOMINAL_TOL    = 100;
	localparam int SAMPLE_MAX     = 4095;

	// Three samples of one ladder channel, first sample in the top bits.
	localparam logic [35:0] LADDER_OPEN  = {3{12'd4095}};
	localparam logic [35:0] LADDER_SHORT = {3{12'd0}};
	localparam logic [35:0] LEFT_A       = {3{12'd1000}};
	localparam logic [35:0] CONFIRM_A    = {3{12'd2000}};
	localparam logic [35:0] BACK_A       = {3{12'd3000}};
	localparam logic [35:0] BACK_EDGE_A  = {3{12'd3569}};
	localparam logic [35:0] VOLUP_B      = {3{12'd1500}};
	localparam logic [35:0] VOLUP_EDGE_B = {3{12'd2305}};
	localparam logic [35:0] MIXED_A      = {12'd4095, 12'd4095, 12'd0};
	localparam logic [35:0] MIXED_B      = {12'd0, 12'd4095, 12'd4095};

	typedef struct {
		in_item_t  poll;
		int        n_typed;
		out_item_t ev0;
		out_item_t ev1;
	} poll_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// Predictor state and its copy of the registers.
	cfg_t        active_cfg;
	logic [2:0]  held_btn;
	logic        holding;
	logic        confirming;
	logic        long_done;
	logic        repeat_started;
	logic [31:0] press_ms;
	logic [31:0] last_event_ms;

	out_item_t   poll_events[$];
	out_item_t   pending_events[$];
	poll_row_t   directed_rows[$];
	logic [31:0] clock_ms;
	int          polls_sent = 0;
	int          mismatches = 0;

	ladder_button_event_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("FAILURE");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic bit steady_window();
		return polls_sent >= STEADY_FROM && polls_sent < STEADY_TO;
	endfunction

	function automatic void clear_hold();
		held_btn       = KEY_NONE;
		holding        = 1'b0;
		confirming     = 1'b0;
		long_done      = 1'b0;
		repeat_started = 1'b0;
	endfunction

	function automatic logic [2:0] decode_button(input in_item_t p);
		logic [13:0] sum_a;
		logic [13:0] sum_b;
		logic [12:0] avg_a;
		logic [12:0] avg_b;
		logic [12:0] tol;
		sum_a = p.ladder_a_sample0 + p.ladder_a_sample1 + p.ladder_a_sample2;
		sum_b = p.ladder_b_sample0 + p.ladder_b_sample1 + p.ladder_b_sample2;
		avg_a = sum_a / SAMPLES_PER_CHANNEL;
		avg_b = sum_b / SAMPLES_PER_CHANNEL;
		tol   = {1'b0, active_cfg.level_tolerance};
		if (p.power_pin_low)           return KEY_POWER;
		if (avg_a < LVL_RIGHT + tol)   return KEY_RIGHT;
		if (avg_a < LVL_LEFT + tol)    return KEY_LEFT;
		if (avg_a < LVL_CONFIRM + tol) return KEY_OK;
		if (avg_a < LVL_BACK + tol)    return KEY_RETURN;
		if (avg_b < LVL_VOLDOWN + tol) return KEY_VOL_DOWN;
		if (avg_b < LVL_VOLUP + tol)   return KEY_VOL_UP;
		return KEY_NONE;
	endfunction

	function automatic void add_event(input logic [2:0] btn, input logic [1:0] kind);
		poll_events.push_back(out_item_t'{btn, kind, 1'b0});
	endfunction

	// Works out the events of one poll into poll_events and advances the press tracker.
	function automatic void predict_events(input in_item_t p);
		logic [2:0]  cur;
		logic [31:0] since_press;
		logic [31:0] since_last;
		logic [15:0] gap_ms;
		cur = decode_button(p);
		since_press = p.now_ms - press_ms;
		since_last  = p.now_ms - last_event_ms;
		poll_events.delete();
		if (holding && confirming) begin
			// Until the debounce time is up every reading is ignored, even no button.
			if (since_press < active_cfg.debounce_time)
				return;
			if (cur == held_btn) begin
				confirming = 1'b0;
				add_event(held_btn, EV_PRESSED);
			end else begin
				clear_hold();
			end
		end else if (cur == KEY_NONE) begin
			if (holding) begin
				add_event(held_btn, EV_RELEASED);
				clear_hold();
			end
		end else if (!holding) begin
			held_btn       = cur;
			holding        = 1'b1;
			long_done      = 1'b0;
			repeat_started = 1'b0;
			press_ms       = p.now_ms;
			last_event_ms  = p.now_ms;
			if (active_cfg.debounce_enable && active_cfg.debounce_time != 16'd0)
				confirming = 1'b1;
			else
				add_event(cur, EV_PRESSED);
		end else begin
			// Events carry the button seen now, which may differ from the held one.
			if (active_cfg.long_press_enable && !long_done &&
					since_press >= active_cfg.long_press_time) begin
				long_done = 1'b1;
				add_event(cur, EV_LONG);
			end
			if (active_cfg.repeat_enable) begin
				gap_ms = repeat_started ? active_cfg.repeat_period
					: active_cfg.repeat_first_delay;
				if (since_last >= gap_ms) begin
					repeat_started = 1'b1;
					last_event_ms  = p.now_ms;
					add_event(cur, EV_REPEAT);
				end
			end
		end
		if (poll_events.size() > 0)
			poll_events[poll_events.size() - 1].last_of_run = 1'b1;
	endfunction

	// Offers one poll beat, waits for it to be taken and records what it should cause.
	task automatic send_poll(input in_item_t p, input int n_typed = PREDICTED,
			input out_item_t e0 = '0, input out_item_t e1 = '0);
		bit taken;
		@(negedge clk);
		while (!steady_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = in_ready;
		end
		polls_sent++;
		predict_events(p);
		if (n_typed == PREDICTED) begin
			foreach (poll_events[k])
				pending_events.push_back(poll_events[k]);
		end else begin
			if (n_typed > 0)
				pending_events.push_back(e0);
			if (n_typed > 1)
				pending_events.push_back(e1);
		end
	endtask

	task automatic add_row(input logic [31:0] ms, input logic pwr, input logic [35:0] a,
			input logic [35:0] b, input int n, input out_item_t e0 = '0,
			input out_item_t e1 = '0);
		poll_row_t r;
		r.poll = '0;
		r.poll.now_ms        = ms;
		r.poll.power_pin_low = pwr;
		{r.poll.ladder_a_sample0, r.poll.ladder_a_sample1, r.poll.ladder_a_sample2} = a;
		{r.poll.ladder_b_sample0, r.poll.ladder_b_sample1, r.poll.ladder_b_sample2} = b;
		r.n_typed = n;
		r.ev0     = e0;
		r.ev1     = e1;
		directed_rows.push_back(r);
	endtask

	// Lets the block run dry: no beat offered, every event back, then a settling wait.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		logic [15:0] wdata [8];
		logic [15:0] junk;
		junk = 16'($urandom);
		// Bits above a register's width are filled with junk; the block must drop them.
		wdata[CFG_DEBOUNCE_EN]   = {junk[15:1], c.debounce_enable};
		wdata[CFG_LONG_EN]       = {junk[14:0], c.long_press_enable};
		wdata[CFG_REPEAT_EN]     = {junk[13:0], junk[15], c.repeat_enable};
		wdata[CFG_DEBOUNCE_TIME] = c.debounce_time;
		wdata[CFG_LONG_TIME]     = c.long_press_time;
		wdata[CFG_REPEAT_FIRST]  = c.repeat_first_delay;
		wdata[CFG_REPEAT_PERIOD] = c.repeat_period;
		wdata[CFG_TOLERANCE]     = {junk[3:0], c.level_tolerance};
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= wdata[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		active_cfg = c;
	endtask

	function automatic logic [15:0] pick_ms();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(1, 40));
			default: return 16'($urandom_range(41, 3000));
		endcase
	endfunction

	function automatic cfg_t pick_cfg(input int phase);
		cfg_t c;
		c.debounce_enable    = $urandom_range(0, 3) != 0;
		c.long_press_enable  = $urandom_range(0, 3) != 0;
		c.repeat_enable      = $urandom_range(0, 3) != 0;
		c.debounce_time      = pick_ms();
		c.long_press_time    = pick_ms();
		c.repeat_first_delay = pick_ms();
		c.repeat_period      = pick_ms();
		case ($urandom_range(0, 7))
			0: c.level_tolerance = 12'd0;
			1: c.level_tolerance = 12'hFFF;
			default: c.level_tolerance = 12'($urandom_range(50, 200));
		endcase
		case (phase)
			0: begin
				c = '0;
				c.debounce_enable   = 1'b1;
				c.long_press_enable = 1'b1;
				c.repeat_enable     = 1'b1;
			end
			1: c = '1;
			2: begin
				c.debounce_enable   = 1'b0;
				c.long_press_enable = 1'b0;
				c.repeat_enable     = 1'b0;
			end
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [11:0] pick_level(input int unsigned lo, input int unsigned hi);
		return 12'($urandom_range(hi, lo));
	endfunction

	// Samples drawn between the nominal levels that bound the chosen button, not its window at tolerance.
	function automatic in_item_t make_reading(input logic [2:0] btn);
		in_item_t    r;
		int unsigned a_lo;
		int unsigned a_hi;
		int unsigned b_lo;
		int unsigned b_hi;
		r = '0;
		r.power_pin_low = (btn == KEY_POWER);
		a_lo = LVL_BACK + NOMINAL_TOL;
		a_hi = SAMPLE_MAX;
		b_lo = 0;
		b_hi = SAMPLE_MAX;
		case (btn)
			KEY_RIGHT:    begin a_lo = 0;           a_hi = LVL_RIGHT - 1;   end
			KEY_LEFT:     begin a_lo = LVL_RIGHT;   a_hi = LVL_LEFT - 1;    end
			KEY_OK:       begin a_lo = LVL_LEFT;    a_hi = LVL_CONFIRM - 1; end
			KEY_RETURN:   begin a_lo = LVL_CONFIRM; a_hi = LVL_BACK - 1;    end
			KEY_VOL_DOWN: begin b_lo = 0;           b_hi = LVL_VOLDOWN - 1; end
			KEY_VOL_UP:   begin b_lo = LVL_VOLDOWN; b_hi = LVL_VOLUP - 1;   end
			KEY_NONE:     b_lo = LVL_VOLUP + NOMINAL_TOL;
			KEY_POWER:    a_lo = 0;
			default: ;
		endcase
		r.ladder_a_sample0 = pick_level(a_lo, a_hi);
		r.ladder_a_sample1 = pick_level(a_lo, a_hi);
		r.ladder_a_sample2 = pick_level(a_lo, a_hi);
		r.ladder_b_sample0 = pick_level(b_lo, b_hi);
		r.ladder_b_sample1 = pick_level(b_lo, b_hi);
		r.ladder_b_sample2 = pick_level(b_lo, b_hi);
		return r;
	endfunction

	function automatic in_item_t noise_reading();
		in_item_t r;
		r = '0;
		r.power_pin_low    = $urandom_range(0, 3) == 0;
		r.ladder_a_sample0 = pick_level(0, SAMPLE_MAX);
		r.ladder_a_sample1 = pick_level(0, SAMPLE_MAX);
		r.ladder_a_sample2 = pick_level(0, SAMPLE_MAX);
		r.ladder_b_sample0 = pick_level(0, SAMPLE_MAX);
		r.ladder_b_sample1 = pick_level(0, SAMPLE_MAX);
		r.ladder_b_sample2 = pick_level(0, SAMPLE_MAX);
		return r;
	endfunction

	task automatic timed_poll(input in_item_t p, input int unsigned span);
		// Now and then a jump of any size, so the timestamp wraps and every bit moves.
		if ($urandom_range(0, 49) == 0)
			clock_ms += $urandom;
		else
			clock_ms += $urandom_range(0, span);
		p.now_ms = clock_ms;
		send_poll(p);
	endtask

	// Mostly press, hold and release gestures with the odd glitch, plus bursts of noise.
	task automatic run_phase(input int polls, input int unsigned span);
		in_item_t reading;
		in_item_t p;
		int       hold;
		int       done;
		done = 0;
		while (done < polls) begin
			if ($urandom_range(0, 6) == 0) begin
				hold = $urandom_range(1, 4);
				repeat (hold) begin
					timed_poll(noise_reading(), span);
					done++;
				end
			end else begin
				reading = make_reading(3'($urandom_range(KEY_POWER, KEY_RIGHT)));
				hold = $urandom_range(1, 12);
				repeat (hold) begin
					p = ($urandom_range(0, 11) == 0) ? noise_reading() : reading;
					timed_poll(p, span);
					done++;
				end
				hold = $urandom_range(1, 3);
				repeat (hold) begin
					timed_poll(make_reading(KEY_NONE), span);
					done++;
				end
			end
		end
	endtask

	// Event receiver, with one long hold-off so that the result queue fills up.
	initial begin
		int stall_left;
		bit stall_done;
		stall_left = 0;
		stall_done = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (!stall_done && polls_sent >= STALL_AT_POLL) begin
				stall_done = 1'b1;
				stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_window() || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("unexpected event beat: button %0d kind %0d",
					out_data.button_id, out_data.event_kind));
			end else begin
				want = pending_events.pop_front();
				if (out_data.button_id !== want.button_id)
					report_mismatch($sformatf("button_id %0d, expected %0d",
						out_data.button_id, want.button_id));
				if (out_data.event_kind !== want.event_kind)
					report_mismatch($sformatf("event_kind %0d, expected %0d",
						out_data.event_kind, want.event_kind));
				if (out_data.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %0b, expected %0b",
						out_data.last_of_run, want.last_of_run));
			end
		end
	end

	initial begin
		cfg_t        cfg;
		int          phase;
		int unsigned max_ms;
		int unsigned span;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		active_cfg    = CFG_RESET;
		press_ms      = '0;
		last_event_ms = '0;
		clear_hold();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed polls under the reset settings: debounce 20, long 1000, repeat 500/100.
		add_row(32'd0,    1'b0, LADDER_OPEN,  LADDER_OPEN,  0);
		add_row(32'd10,   1'b0, LADDER_SHORT, LADDER_OPEN,  0);
		add_row(32'd15,   1'b0, LADDER_OPEN,  LADDER_OPEN,  0);
		add_row(32'd30,   1'b0, LADDER_SHORT, LADDER_OPEN,  1,
			out_item_t'{KEY_RIGHT, EV_PRESSED, 1'b1});
		add_row(32'd600,  1'b0, LADDER_SHORT, LADDER_OPEN,  1,
			out_item_t'{KEY_RIGHT, EV_REPEAT, 1'b1});
		add_row(32'd700,  1'b0, LADDER_SHORT, LADDER_OPEN,  1,
			out_item_t'{KEY_RIGHT, EV_REPEAT, 1'b1});
		add_row(32'd1100, 1'b0, LEFT_A,       LADDER_OPEN,  2,
			out_item_t'{KEY_LEFT, EV_LONG, 1'b0}, out_item_t'{KEY_LEFT, EV_REPEAT, 1'b1});
		add_row(32'd1150, 1'b0, LADDER_OPEN,  LADDER_OPEN,  1,
			out_item_t'{KEY_RIGHT, EV_RELEASED, 1'b1});
		// A press that reads differently at the confirming poll is dropped silently.
		add_row(32'd1200, 1'b0, CONFIRM_A,    LADDER_OPEN,  0);
		add_row(32'd1220, 1'b0, BACK_A,       LADDER_OPEN,  0);
		add_row(32'd1230, 1'b0, BACK_A,       LADDER_OPEN,  0);
		add_row(32'd1250, 1'b1, LADDER_SHORT, LADDER_SHORT, 0);
		add_row(32'd1260, 1'b1, LADDER_OPEN,  LADDER_OPEN,  0);
		add_row(32'd1280, 1'b1, LADDER_OPEN,  LADDER_OPEN,  1,
			out_item_t'{KEY_POWER, EV_PRESSED, 1'b1});
		add_row(32'd1290, 1'b0, LADDER_OPEN,  LADDER_OPEN,  1,
			out_item_t'{KEY_POWER, EV_RELEASED, 1'b1});
		add_row(32'd1300, 1'b0, LADDER_OPEN,  LADDER_SHORT, 0);
		add_row(32'd1320, 1'b0, LADDER_OPEN,  LADDER_SHORT, 1,
			out_item_t'{KEY_VOL_DOWN, EV_PRESSED, 1'b1});
		add_row(32'd1330, 1'b0, LADDER_OPEN,  VOLUP_B,      0);
		add_row(32'd1340, 1'b0, LADDER_OPEN,  LADDER_OPEN,  1,
			out_item_t'{KEY_VOL_DOWN, EV_RELEASED, 1'b1});
		// Press just before the timestamp wraps, confirmed and repeated after it.
		add_row(32'hFFFF_FFF0, 1'b0, LADDER_SHORT, LADDER_OPEN, 0);
		add_row(32'h0000_0004, 1'b0, LADDER_SHORT, LADDER_OPEN, 1,
			out_item_t'{KEY_RIGHT, EV_PRESSED, 1'b1});
		add_row(32'h0000_01E4, 1'b0, LADDER_SHORT, LADDER_OPEN, 1,
			out_item_t'{KEY_RIGHT, EV_REPEAT, 1'b1});
		add_row(32'h0000_0300, 1'b0, MIXED_A,      MIXED_B,      PREDICTED);
		add_row(32'h0000_0400, 1'b0, BACK_EDGE_A,  LADDER_OPEN,  PREDICTED);
		add_row(32'h0000_0410, 1'b0, LADDER_OPEN,  VOLUP_EDGE_B, PREDICTED);
		foreach (directed_rows[i])
			send_poll(directed_rows[i].poll, directed_rows[i].n_typed,
				directed_rows[i].ev0, directed_rows[i].ev1);
		settle();

		clock_ms = 32'h0000_1000;
		phase = 0;
		while (polls_sent < directed_rows.size() + RANDOM_POLLS) begin
			cfg = pick_cfg(phase);
			apply_cfg(cfg);
			// Time steps scale with the longest setting so that holds reach their events.
			max_ms = cfg.debounce_time;
			if (cfg.long_press_time > max_ms)
				max_ms = cfg.long_press_time;
			if (cfg.repeat_first_delay > max_ms)
				max_ms = cfg.repeat_first_delay;
			if (cfg.repeat_period > max_ms)
				max_ms = cfg.repeat_period;
			span = $urandom_range(1, max_ms / 4 + 8);
			run_phase($urandom_range(60, 220), span);
			settle();
			phase++;
		end

		if (mismatches == 0 && pending_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
